// ===== hw/rtl/bbc_pkg.sv =====
`default_nettype none
package bbc_pkg;

    localparam int QDEPTH = 4;
    localparam int QPW    = 2;
    localparam int QCW    = 3;

    typedef enum logic [1:0] {
        DIV4,
        DIV6,
        DIV9
    } div_t;

    // one pending result: four channel sums, red lowest
    typedef struct packed {
        logic [3:0][11:0] sum;
        div_t             div;
        logic [9:0]       row;
        logic [9:0]       col;
    } job_t;

    typedef struct packed {
        logic [3:0]       mask;
        job_t [3:0]       job;
    } rec_t;

    // truncated mean; reciprocals are exact over the reachable sum range
    function automatic logic [7:0] mean8(input logic [11:0] s, input div_t d);
        logic [25:0] p;
        logic [7:0]  q;
        begin
            p = '0;
            case (d)
                DIV4: begin
                    q = s[9:2];
                end
                DIV6: begin
                    p = 26'(s) * 26'd10923;
                    q = p[23:16];
                end
                DIV9: begin
                    p = 26'(s) * 26'd7282;
                    q = p[23:16];
                end
                default: begin
                    q = '0;
                end
            endcase
            return q;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/box_blur_3x3_edge_clamped_unit.sv =====
// A result passes the input stage register, the queue and the output register after its releasing beat is accepted.
// Throughput: one input beat per cycle while the queue has room; results leave at one per cycle
// while m_tready is high, so a beat that releases n results (up to four, at row ends and in the last
// row) sends them out one after another, buffered by a four-entry queue of result records.
// Reset (aresetn low, synchronous) sets the side to MAX_SIDE capped at 1024 and restarts at row 0.
`default_nettype none
module box_blur_3x3_edge_clamped_unit #(
    parameter int MAX_SIDE = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // in_red, in_green, in_blue, in_alpha
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // out_red, out_green, out_blue, out_alpha,
                                        // out_row, out_col, zero pad
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);

    logic                       push, pop;
    bbc_pkg::rec_t              push_rec, head;
    logic [bbc_pkg::QCW-1:0]    count;

    bbc_front #(.MAX_SIDE(MAX_SIDE)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .q_count(count), .push(push), .push_rec(push_rec)
    );

    bbc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_rec(push_rec), .pop(pop),
        .head(head), .count(count)
    );

    bbc_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(count != '0), .q_head(head), .q_pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/bbc_ram.sv =====
`default_nettype none
module bbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bbc_front.sv =====
`default_nettype none
module bbc_front #(
    parameter int MAX_SIDE = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [10:0]          cfg_data,
    input  wire logic [bbc_pkg::QCW-1:0] q_count,
    output logic                      push,
    output bbc_pkg::rec_t             push_rec
);

    localparam int AW       = $clog2(MAX_SIDE);
    localparam int XW       = AW + 11;
    localparam int RST_SIDE = (MAX_SIDE < 1024) ? MAX_SIDE : 1024;

    logic [10:0]            side_reg;
    logic [AW-1:0]          row_reg, row_next, col_reg, col_next;
    logic                   v1_reg;
    logic [31:0]            pix_reg;
    logic [AW-1:0]          r1_reg, c1_reg;
    logic [2:0][3:0][11:0]  win_reg, win2_reg;

    logic [31:0] rd0, rd1, top, mid;
    logic        accept;
    logic [XW-1:0] side_x, col_x, row_x, r1_x, c1_x;
    logic rge1, rge2, c_ge1, c_eq1, c_ge2, c_last, r_last;
    logic [3:0][11:0] col3, col2, s0, s1, s2, s3;
    logic [10:0] cfg_side;
    logic [AW-1:0] rm1, cm1;
    logic [AW+9:0] r_e, rm1_e, c_e, cm1_e;

    assign cfg_ready = 1'b1;
    assign s_tready  = ({1'b0, q_count} + 4'(v1_reg)) < 4'(bbc_pkg::QDEPTH);
    assign accept    = s_tvalid && s_tready;

    bbc_ram #(.WIDTH(32), .DEPTH(MAX_SIDE)) u_bank0 (
        .aclk(aclk), .wr_en(v1_reg && !r1_reg[0]), .wr_addr(c1_reg), .wr_data(pix_reg),
        .rd_addr(col_reg), .rd_data(rd0)
    );
    bbc_ram #(.WIDTH(32), .DEPTH(MAX_SIDE)) u_bank1 (
        .aclk(aclk), .wr_en(v1_reg && r1_reg[0]), .wr_addr(c1_reg), .wr_data(pix_reg),
        .rd_addr(col_reg), .rd_data(rd1)
    );

    always_comb begin
        side_x = XW'(side_reg);
        col_x  = XW'(col_reg) + XW'(1);
        row_x  = XW'(row_reg) + XW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_x == side_x) begin
                col_next = '0;
                row_next = (row_x == side_x) ? '0 : row_x[AW-1:0];
            end else begin
                col_next = col_x[AW-1:0];
            end
        end
        if ({21'b0, cfg_data} < 32'd2) begin
            cfg_side = 11'd2;
        end else if ({21'b0, cfg_data} > 32'(MAX_SIDE)) begin
            cfg_side = 11'(MAX_SIDE);
        end else begin
            cfg_side = cfg_data;
        end
    end

    // top row sits in the bank of this row's parity, middle row in the other
    always_comb begin
        r1_x   = XW'(r1_reg) + XW'(1);
        c1_x   = XW'(c1_reg) + XW'(1);
        rge1   = r1_reg != '0;
        rge2   = r1_reg > AW'(1);
        c_ge1  = c1_reg != '0;
        c_eq1  = c1_reg == AW'(1);
        c_ge2  = c1_reg > AW'(1);
        c_last = c1_x == side_x;
        r_last = r1_x == side_x;
        mid    = r1_reg[0] ? rd0 : rd1;
        top    = rge2 ? (r1_reg[0] ? rd1 : rd0) : 32'd0;
        for (int ch = 0; ch < 4; ch++) begin
            col2[ch] = 12'(mid[8*ch +: 8]) + 12'(pix_reg[8*ch +: 8]);
            col3[ch] = col2[ch] + 12'(top[8*ch +: 8]);
            s1[ch]   = win_reg[2][ch] + col3[ch];
            s0[ch]   = s1[ch] + (c_eq1 ? 12'd0 : win_reg[1][ch]);
            s3[ch]   = win2_reg[2][ch] + col2[ch];
            s2[ch]   = s3[ch] + (c_ge2 ? win2_reg[1][ch] : 12'd0);
        end
        rm1   = r1_reg - AW'(1);
        cm1   = c1_reg - AW'(1);
        r_e   = (AW+10)'(r1_reg);
        rm1_e = (AW+10)'(rm1);
        c_e   = (AW+10)'(c1_reg);
        cm1_e = (AW+10)'(cm1);

        push_rec.mask[0] = rge1 && c_ge1;
        push_rec.mask[1] = rge1 && c_last;
        push_rec.mask[2] = rge1 && r_last && c_ge1;
        push_rec.mask[3] = rge1 && r_last && c_last;

        push_rec.job[0].sum = s0;
        push_rec.job[0].div = rge2 ? (c_eq1 ? bbc_pkg::DIV6 : bbc_pkg::DIV9)
                                   : (c_eq1 ? bbc_pkg::DIV4 : bbc_pkg::DIV6);
        push_rec.job[0].row = rm1_e[9:0];
        push_rec.job[0].col = cm1_e[9:0];

        push_rec.job[1].sum = s1;
        push_rec.job[1].div = rge2 ? bbc_pkg::DIV6 : bbc_pkg::DIV4;
        push_rec.job[1].row = rm1_e[9:0];
        push_rec.job[1].col = c_e[9:0];

        push_rec.job[2].sum = s2;
        push_rec.job[2].div = c_ge2 ? bbc_pkg::DIV6 : bbc_pkg::DIV4;
        push_rec.job[2].row = r_e[9:0];
        push_rec.job[2].col = cm1_e[9:0];

        push_rec.job[3].sum = s3;
        push_rec.job[3].div = bbc_pkg::DIV4;
        push_rec.job[3].row = r_e[9:0];
        push_rec.job[3].col = c_e[9:0];

        push = v1_reg && (push_rec.mask != 4'b0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= 11'(RST_SIDE);
            row_reg  <= '0;
            col_reg  <= '0;
            v1_reg   <= 1'b0;
            win_reg  <= '0;
            win2_reg <= '0;
        end else if (cfg_valid) begin
            side_reg <= cfg_side;
            row_reg  <= '0;
            col_reg  <= '0;
            v1_reg   <= 1'b0;
            win_reg  <= '0;
            win2_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
            v1_reg  <= accept;
            if (v1_reg && rge1) begin
                win_reg  <= {col3, win_reg[2], win_reg[1]};
                win2_reg <= {col2, win2_reg[2], win2_reg[1]};
            end
        end
    end

    // hold the beat for the cycle the bank read returns
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg <= s_tdata;
            r1_reg  <= row_reg;
            c1_reg  <= col_reg;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bbc_queue.sv =====
`default_nettype none
module bbc_queue (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire bbc_pkg::rec_t           push_rec,
    input  wire logic                    pop,
    output bbc_pkg::rec_t                head,
    output logic [bbc_pkg::QCW-1:0]      count
);

    bbc_pkg::rec_t             mem_reg [bbc_pkg::QDEPTH];
    logic [bbc_pkg::QPW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [bbc_pkg::QCW-1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + bbc_pkg::QCW'(push) - bbc_pkg::QCW'(pop);
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bbc_back.sv =====
`default_nettype none
module bbc_back (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    input  wire bbc_pkg::rec_t q_head,
    output logic              q_pop,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [55:0]       m_tdata,
    output logic              m_tlast
);

    logic [3:0]   done_reg, done_next;
    logic         m_valid_reg;
    logic [55:0]  m_data_reg;
    logic         m_last_reg;

    logic [3:0]   pend, sel_hot, rest;
    logic [1:0]   sel;
    logic         load, last;
    bbc_pkg::job_t jb;
    logic [31:0]  mean;

    always_comb begin
        pend    = q_head.mask & ~done_reg;
        sel     = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (pend[i]) begin
                sel = 2'(i);
            end
        end
        sel_hot = 4'b0001 << sel;
        rest    = pend & ~sel_hot;
        last    = rest == 4'b0;
        load    = q_valid && (!m_valid_reg || m_tready);
        q_pop   = load && last;
        done_next = done_reg;
        if (load) begin
            done_next = last ? 4'b0 : (done_reg | sel_hot);
        end
        jb = q_head.job[sel];
        for (int ch = 0; ch < 4; ch++) begin
            mean[8*ch +: 8] = bbc_pkg::mean8(jb.sum[ch], jb.div);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= {4'b0, jb.col, jb.row, mean};
            m_last_reg <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

// ===== verif/box_blur_3x3_edge_clamped_unit_test.sv =====
`default_nettype none
module box_blur_3x3_edge_clamped_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE_MAX = 1024;
    localparam int CFG_SETTLE = 8;

    typedef struct {
        logic [3:0][7:0] chan;   // red lowest
        logic [9:0]      row;
        logic [9:0]      col;
        logic            last;
    } blur_pix_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;

    box_blur_3x3_edge_clamped_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // shadow of the block's state
    int              img_side;
    int              pos_row;
    int              pos_col;
    logic [31:0]     line_buf [2*SIDE_MAX];
    int              col_sum [3][4];
    blur_pix_t       blurred_q [$];
    int              errors = 0;
    bit              calm = 1'b0;   // no idling on either side

    function automatic int line_base(int r);
        return (r % 2) ? SIDE_MAX : 0;
    endfunction

    function automatic blur_pix_t mean_pix(int s[4], int divisor, int r, int c);
        blur_pix_t p;
        for (int k = 0; k < 4; k++) p.chan[k] = 8'(s[k] / divisor);
        p.row = 10'(r);
        p.col = 10'(c);
        p.last = 1'b0;
        return p;
    endfunction

    function automatic void window_total(int lo, output int s[4]);
        for (int k = 0; k < 4; k++) begin
            s[k] = 0;
            for (int i = lo; i < 3; i++) s[k] += col_sum[i][k];
        end
    endfunction

    function automatic void two_row_total(int r, int lo, int hi, output int s[4]);
        logic [31:0] a, b;
        for (int k = 0; k < 4; k++) s[k] = 0;
        for (int c = lo; c <= hi; c++) begin
            a = line_buf[line_base(r - 1) + c];
            b = line_buf[line_base(r) + c];
            for (int k = 0; k < 4; k++) s[k] += a[8*k +: 8] + b[8*k +: 8];
        end
    endfunction

    function automatic void predict_blur(logic [31:0] px);
        int r, c, rows, lo, s[4];
        logic [31:0] top, mid;
        blur_pix_t outs [$];
        r = pos_row;
        c = pos_col;
        if (r >= 1) begin
            top = (r >= 2) ? line_buf[line_base(r) + c] : '0;
            mid = line_buf[line_base(r - 1) + c];
            col_sum[0] = col_sum[1];
            col_sum[1] = col_sum[2];
            for (int k = 0; k < 4; k++)
                col_sum[2][k] = top[8*k +: 8] + mid[8*k +: 8] + px[8*k +: 8];
        end
        line_buf[line_base(r) + c] = px;
        if (r >= 1) begin
            rows = (r >= 2) ? 3 : 2;
            if (c >= 1) begin
                lo = (c == 1) ? 1 : 0;
                window_total(lo, s);
                outs.push_back(mean_pix(s, rows * (3 - lo), r - 1, c - 1));
            end
            if (c == img_side - 1) begin
                window_total(1, s);
                outs.push_back(mean_pix(s, rows * 2, r - 1, c));
            end
            if (r == img_side - 1) begin
                if (c >= 1) begin
                    lo = (c >= 2) ? c - 2 : 0;
                    two_row_total(r, lo, c, s);
                    outs.push_back(mean_pix(s, 2 * (c - lo + 1), r, c - 1));
                end
                if (c == img_side - 1) begin
                    two_row_total(r, c - 1, c, s);
                    outs.push_back(mean_pix(s, 4, r, c));
                end
            end
        end
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) blurred_q.push_back(outs[i]);
        c++;
        if (c >= img_side) begin
            c = 0;
            r++;
            if (r >= img_side) r = 0;
        end
        pos_row = r;
        pos_col = c;
    endfunction

    function automatic void restart_image();
        pos_row = 0;
        pos_col = 0;
        foreach (col_sum[i, k]) col_sum[i][k] = 0;
    endfunction

    // sink: random back-pressure and result checks
    always @(posedge aclk) begin
        blur_pix_t want;
        blur_pix_t got;
        if (aresetn && m_tvalid && m_tready) begin
            for (int k = 0; k < 4; k++) got.chan[k] = m_tdata[8*k +: 8];
            got.row = m_tdata[41:32];
            got.col = m_tdata[51:42];
            got.last = m_tlast;
            if (blurred_q.size() == 0) begin
                $display("%0t: unexpected beat row %0d col %0d", $realtime, got.row, got.col);
                errors++;
            end else begin
                want = blurred_q.pop_front();
                for (int k = 0; k < 4; k++)
                    if (got.chan[k] !== want.chan[k]) begin
                        $display("%0t: channel %0d at (%0d,%0d) expected %0d actual %0d",
                                 $realtime, k, want.row, want.col, want.chan[k], got.chan[k]);
                        errors++;
                    end
                if (got.row !== want.row || got.col !== want.col) begin
                    $display("%0t: position expected (%0d,%0d) actual (%0d,%0d)",
                             $realtime, want.row, want.col, got.row, got.col);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: tlast at (%0d,%0d) expected %0b actual %0b",
                             $realtime, want.row, want.col, want.last, got.last);
                    errors++;
                end
            end
        end
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
    end

    task automatic send_pixel(logic [31:0] px);
        if (!calm && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_blur(px);
    endtask

    // hold the source quiet and let the block drain before touching the side
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (blurred_q.size() != 0) @(posedge aclk);
        repeat (CFG_SETTLE) @(posedge aclk);
    endtask

    task automatic write_side(logic [10:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        img_side = (v < 2) ? 2 : ((v > SIDE_MAX) ? SIDE_MAX : int'(v));
        restart_image();
    endtask

    function automatic logic [31:0] rand_pixel();
        logic [31:0] px;
        px = $urandom();
        for (int k = 0; k < 4; k++)
            case ($urandom_range(5))
                0: px[8*k +: 8] = 8'h00;
                1: px[8*k +: 8] = 8'hFF;
                default: ;
            endcase
        return px;
    endfunction

    task automatic test_extreme_values();
        write_side(11'd0);              // clamps up to two
        repeat (4) send_pixel(32'hFFFF_FFFF);
        repeat (4) send_pixel(32'h0000_0000);
        write_side(11'd3);
        for (int i = 0; i < 9; i++) send_pixel(32'hFFFF_FFFF);
    endtask

    task automatic test_side_clamp();
        write_side(11'd1);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'hFF00_FF00);
        send_pixel(32'h8001_7F80);
        send_pixel(32'h0102_0304);
        write_side(11'd2047);           // clamps down to the largest side
        for (int i = 0; i < 6; i++) send_pixel(rand_pixel());
    endtask

    task automatic test_restart_mid_image();
        write_side(11'd5);
        for (int i = 0; i < 12; i++) send_pixel(rand_pixel());
        write_side(11'd4);
        for (int i = 0; i < 16; i++) send_pixel(rand_pixel());
    endtask

    task automatic test_random_images();
        int sent, n;
        sent = 0;
        while (sent < 100) begin
            write_side(11'($urandom_range(8, 2)));
            n = img_side * img_side * $urandom_range(2, 1);
            if ($urandom_range(9) == 0) n = $urandom_range(img_side * img_side - 1, 1);
            calm = ($urandom_range(4) == 0);
            for (int i = 0; i < n; i++) send_pixel(rand_pixel());
            sent += n;
        end
        calm = 1'b0;
    endtask

    initial begin
        img_side = SIDE_MAX;
        restart_image();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extreme_values();
        test_side_clamp();
        test_restart_mid_image();
        test_random_images();
        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_ram.sv
hw/rtl/bbc_front.sv
hw/rtl/bbc_queue.sv
hw/rtl/bbc_back.sv
hw/rtl/box_blur_3x3_edge_clamped_unit.sv
verif/box_blur_3x3_edge_clamped_unit_test.sv
